// ----- rtl/bsd_pkg.sv -----
// Shared constants, types and register codes of the baseline spike detector.
`default_nettype none

package bsd_pkg;

    // Number of readings held in the baseline chain.
    localparam int BASELINE_DEPTH = 10;

    localparam int IAQ_W   = 13;
    localparam int VOC_W   = 20;
    localparam int CO2_W   = 16;
    localparam int PM25_W  = 10;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;

    localparam int DEPTH_W   = $clog2(BASELINE_DEPTH);
    localparam int IAQ_SUM_W = IAQ_W + DEPTH_W;
    localparam int VOC_SUM_W = VOC_W + DEPTH_W;
    localparam int CO2_SUM_W = CO2_W + DEPTH_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IAQ_THR  = 3'd0,
        CFG_VOC_THR  = 3'd1,
        CFG_CO2_THR  = 3'd2,
        CFG_PM25_THR = 3'd3,
        CFG_MIN_MS   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CO2_W-1:0] co2;
        logic [VOC_W-1:0] voc;
        logic [IAQ_W-1:0] iaq;
    } sample_t;

    typedef struct packed {
        logic [CO2_SUM_W-1:0] co2;
        logic [VOC_SUM_W-1:0] voc;
        logic [IAQ_SUM_W-1:0] iaq;
    } sums_t;

    // Input tdata, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]        pad;
        logic [TIME_W-1:0] time_ms;
        logic [PM25_W-1:0] pm25_value;
        logic [CO2_W-1:0]  co2_value;
        logic [VOC_W-1:0]  voc_value;
        logic [IAQ_W-1:0]  iaq_value;
    } in_data_t;

    // Output tdata, last field in the lowest bits.
    typedef struct packed {
        logic               peak_pm25_valid;
        logic [PM25_W-1:0]  peak_pm25;
        logic [CO2_W-1:0]   peak_co2;
        logic [VOC_W-1:0]   peak_voc;
        logic [IAQ_W-1:0]   peak_iaq;
        logic [TIME_W-1:0]  duration_ms;
        logic [COUNT_W-1:0] spike_count;
        logic               spike_recorded;
        logic               spike_started;
        logic               in_spike;
        logic               window_full;
    } out_data_t;

endpackage

`default_nettype wire

// ----- rtl/baseline_spike_detector.sv -----
// Top level of the baseline spike detector: stream ports, thresholds, spike tracking.
`default_nettype none

// Baseline spike detector. Each input transaction carries one air-quality
// reading (IAQ, VOC, CO2, optional PM2.5 and a millisecond time stamp) and
// produces exactly one result transaction. While no spike is in progress
// and IAQ is nonzero, the reading is pushed into a chain of BASELINE_DEPTH
// cells that holds the baseline window; running sums follow the chain, so
// the baseline costs one add and one subtract per channel. Once the chain
// has been filled once, a channel spikes when DEPTH*value exceeds
// sum + DEPTH*threshold (exact, no division); a valid PM2.5 reading spikes
// above its absolute threshold. The block reports spike start, holds the
// peaks, and on exit counts the spike (saturating at 65535) if it lasted at
// least min_spike_ms. The whole update, from baseline push through detection
// to the spike state, is combinational, and one output register separates
// the result stream, so a new reading is taken in every cycle in which the
// result register is empty or being drained. Configuration writes take
// effect at the next edge and are meant to be issued while no transaction
// is in flight.
module baseline_spike_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [bsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Reading stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // iaq_value[12:0], voc_value[32:13], co2_value[48:33], pm25_value[58:49],
    // time_ms[90:59], zero fill[95:91]
    input  logic [bsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // pm25_valid[0]
    input  logic                               s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // window_full[0], in_spike[1], spike_started[2], spike_recorded[3],
    // spike_count[19:4], duration_ms[51:20], peak_iaq[64:52], peak_voc[84:65],
    // peak_co2[100:85], peak_pm25[110:101], peak_pm25_valid[111]
    output logic [bsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import bsd_pkg::*;

    // Configuration registers.
    logic [IAQ_W-1:0]  iaq_thr_reg;
    logic [VOC_W-1:0]  voc_thr_reg;
    logic [CO2_W-1:0]  co2_thr_reg;
    logic [PM25_W-1:0] pm25_thr_reg;
    logic [TIME_W-1:0] min_ms_reg;

    // Spike state.
    logic               spiking_reg,   spiking_next;
    logic [TIME_W-1:0]  start_reg,     start_next;
    logic [IAQ_W-1:0]   pk_iaq_reg,    pk_iaq_next;
    logic [VOC_W-1:0]   pk_voc_reg,    pk_voc_next;
    logic [CO2_W-1:0]   pk_co2_reg,    pk_co2_next;
    logic [PM25_W-1:0]  pk_pm25_reg,   pk_pm25_next;
    logic               pk_pmv_reg,    pk_pmv_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    // Output register.
    logic               m_valid_reg;
    out_data_t          m_data_reg;

    in_data_t  din;
    sample_t   sample;
    sums_t     sums_next;
    logic      ready_next;
    logic      accept;
    logic      push;
    logic      pmv;

    logic [IAQ_SUM_W-1:0] iaq_scaled;
    logic [VOC_SUM_W-1:0] voc_scaled;
    logic [CO2_SUM_W-1:0] co2_scaled;
    logic [IAQ_SUM_W:0]   iaq_limit;
    logic [VOC_SUM_W:0]   voc_limit;
    logic [CO2_SUM_W:0]   co2_limit;
    logic                 detected;
    logic                 started;
    logic                 ended;
    logic                 recorded;
    logic [TIME_W-1:0]    duration;
    out_data_t            result;

    assign din    = in_data_t'(s_axis_tdata);
    assign pmv    = s_axis_tuser;
    assign sample = '{co2: din.co2_value, voc: din.voc_value, iaq: din.iaq_value};

    // Take a reading whenever the result register is empty or drains now.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Readings during a spike, or with IAQ zero, stay out of the baseline.
    assign push = accept && !spiking_reg && (din.iaq_value != '0);

    bsd_baseline u_baseline (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .sample_in  (sample),
        .sums_next  (sums_next),
        .ready_next (ready_next)
    );

    // Exact mean test: DEPTH*value > sum + DEPTH*threshold, against the
    // baseline that already includes this reading when it is pushed.
    always_comb
    begin
        iaq_scaled = IAQ_SUM_W'(din.iaq_value) * IAQ_SUM_W'(BASELINE_DEPTH);
        voc_scaled = VOC_SUM_W'(din.voc_value) * VOC_SUM_W'(BASELINE_DEPTH);
        co2_scaled = CO2_SUM_W'(din.co2_value) * CO2_SUM_W'(BASELINE_DEPTH);
        iaq_limit  = (IAQ_SUM_W+1)'(sums_next.iaq)
                   + (IAQ_SUM_W+1)'(iaq_thr_reg) * (IAQ_SUM_W+1)'(BASELINE_DEPTH);
        voc_limit  = (VOC_SUM_W+1)'(sums_next.voc)
                   + (VOC_SUM_W+1)'(voc_thr_reg) * (VOC_SUM_W+1)'(BASELINE_DEPTH);
        co2_limit  = (CO2_SUM_W+1)'(sums_next.co2)
                   + (CO2_SUM_W+1)'(co2_thr_reg) * (CO2_SUM_W+1)'(BASELINE_DEPTH);
        detected   = ready_next &&
                     (({1'b0, iaq_scaled} > iaq_limit) ||
                      ({1'b0, voc_scaled} > voc_limit) ||
                      ({1'b0, co2_scaled} > co2_limit) ||
                      (pmv && (din.pm25_value > pm25_thr_reg)));
    end

    // Spike entry, exit and peak hold.
    always_comb
    begin
        spiking_next = spiking_reg;
        start_next   = start_reg;
        pk_iaq_next  = pk_iaq_reg;
        pk_voc_next  = pk_voc_reg;
        pk_co2_next  = pk_co2_reg;
        pk_pm25_next = pk_pm25_reg;
        pk_pmv_next  = pk_pmv_reg;
        count_next   = count_reg;
        started      = 1'b0;
        ended        = 1'b0;
        recorded     = 1'b0;
        duration     = din.time_ms - start_reg;

        if (detected && !spiking_reg)
        begin
            // Open a spike: restart the clock and seed the peaks.
            spiking_next = 1'b1;
            started      = 1'b1;
            start_next   = din.time_ms;
            duration     = '0;
            pk_iaq_next  = din.iaq_value;
            pk_voc_next  = din.voc_value;
            pk_co2_next  = din.co2_value;
            pk_pm25_next = pmv ? din.pm25_value : '0;
            pk_pmv_next  = pmv;
        end
        else if (!detected && spiking_reg)
        begin
            // Close the spike; count it only if it lasted long enough.
            spiking_next = 1'b0;
            ended        = 1'b1;
            if (duration >= min_ms_reg)
            begin
                recorded = 1'b1;
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        else if (spiking_reg)
        begin
            if (din.iaq_value > pk_iaq_reg)
            begin
                pk_iaq_next = din.iaq_value;
            end
            if (din.voc_value > pk_voc_reg)
            begin
                pk_voc_next = din.voc_value;
            end
            if (din.co2_value > pk_co2_reg)
            begin
                pk_co2_next = din.co2_value;
            end
            if (pmv)
            begin
                if (!pk_pmv_reg || (din.pm25_value > pk_pm25_reg))
                begin
                    pk_pm25_next = din.pm25_value;
                end
                pk_pmv_next = 1'b1;
            end
        end

        result.window_full    = ready_next;
        result.in_spike       = spiking_next;
        result.spike_started  = started;
        result.spike_recorded = recorded;
        result.spike_count    = count_next;
        if (spiking_next || ended)
        begin
            result.duration_ms     = duration;
            result.peak_iaq        = pk_iaq_next;
            result.peak_voc        = pk_voc_next;
            result.peak_co2        = pk_co2_next;
            result.peak_pm25       = pk_pmv_next ? pk_pm25_next : '0;
            result.peak_pm25_valid = pk_pmv_next;
        end
        else
        begin
            // Idle result: no spike to describe.
            result.duration_ms     = '0;
            result.peak_iaq        = '0;
            result.peak_voc        = '0;
            result.peak_co2        = '0;
            result.peak_pm25       = '0;
            result.peak_pm25_valid = 1'b0;
        end
    end

    // Configuration registers: unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iaq_thr_reg  <= IAQ_W'(100);
            voc_thr_reg  <= VOC_W'(50);
            co2_thr_reg  <= CO2_W'(50);
            pm25_thr_reg <= PM25_W'(25);
            min_ms_reg   <= TIME_W'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_IAQ_THR:  iaq_thr_reg  <= cfg_wdata[IAQ_W-1:0];
                CFG_VOC_THR:  voc_thr_reg  <= cfg_wdata[VOC_W-1:0];
                CFG_CO2_THR:  co2_thr_reg  <= cfg_wdata[CO2_W-1:0];
                CFG_PM25_THR: pm25_thr_reg <= cfg_wdata[PM25_W-1:0];
                CFG_MIN_MS:   min_ms_reg   <= cfg_wdata[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    // Spike state: advance once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spiking_reg <= 1'b0;
            start_reg   <= '0;
            pk_iaq_reg  <= '0;
            pk_voc_reg  <= '0;
            pk_co2_reg  <= '0;
            pk_pm25_reg <= '0;
            pk_pmv_reg  <= 1'b0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            spiking_reg <= spiking_next;
            start_reg   <= start_next;
            pk_iaq_reg  <= pk_iaq_next;
            pk_voc_reg  <= pk_voc_next;
            pk_co2_reg  <= pk_co2_next;
            pk_pm25_reg <= pk_pm25_next;
            pk_pmv_reg  <= pk_pmv_next;
            count_reg   <= count_next;
        end
    end

    // Result register: load on accept, clear valid once drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            m_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_data_reg);

    // A reported spike start always leaves a spike open with zero duration.
    a_start_open: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.spike_started) |->
            (m_data_reg.in_spike && (m_data_reg.duration_ms == '0)))
        else $error("spike start without open spike");

    // A recorded spike has ended.
    a_record_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.spike_recorded) |-> !m_data_reg.in_spike)
        else $error("spike recorded while still in progress");

    // No spike can be open before the baseline is ready.
    a_spike_needs_base: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.in_spike) |-> m_data_reg.window_full)
        else $error("spike reported without a ready baseline");

    // The counter moves by at most one per transaction.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((count_reg == $past(count_reg)) ||
                    (count_reg == $past(count_reg) + 1'b1)))
        else $error("spike count jumped");

endmodule

`default_nettype wire

// ----- rtl/bsd_cell.sv -----
// One baseline cell: holds one reading and passes it on to its neighbor on a push.
`default_nettype none

module bsd_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  bsd_pkg::sample_t sample_in,
    output bsd_pkg::sample_t sample_out
);
    import bsd_pkg::*;

    sample_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift_en)
        begin
            data_reg <= sample_in;
        end
    end

    assign sample_out = data_reg;

endmodule

`default_nettype wire

// ----- rtl/bsd_baseline.sv -----
// Baseline chain of cells with running sums and the fill tracker.
`default_nettype none

module bsd_baseline (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bsd_pkg::sample_t sample_in,
    output bsd_pkg::sums_t   sums_next,
    output logic             ready_next
);
    import bsd_pkg::*;

    sample_t chain [BASELINE_DEPTH+1];
    sums_t   sums_reg;
    logic    ready_reg;
    logic [DEPTH_W-1:0] fill_reg;
    sample_t oldest;

    assign chain[0] = sample_in;

    for (genvar i = 0; i < BASELINE_DEPTH; i++)
    begin : g_cell
        bsd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (push),
            .sample_in  (chain[i]),
            .sample_out (chain[i+1])
        );
    end

    // The last cell drops out of the window on a push.
    assign oldest = chain[BASELINE_DEPTH];

    always_comb
    begin
        sums_next = sums_reg;
        if (push)
        begin
            sums_next.iaq = sums_reg.iaq + IAQ_SUM_W'(sample_in.iaq) - IAQ_SUM_W'(oldest.iaq);
            sums_next.voc = sums_reg.voc + VOC_SUM_W'(sample_in.voc) - VOC_SUM_W'(oldest.voc);
            sums_next.co2 = sums_reg.co2 + CO2_SUM_W'(sample_in.co2) - CO2_SUM_W'(oldest.co2);
        end
        ready_next = ready_reg || (push && (fill_reg == DEPTH_W'(BASELINE_DEPTH - 1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg  <= '0;
            ready_reg <= 1'b0;
            fill_reg  <= '0;
        end
        else if (push)
        begin
            sums_reg  <= sums_next;
            ready_reg <= ready_next;
            if (!ready_reg)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
